>>> src/nsdn_pkg.sv
// Shared types and codes of the segment discovery node controller.
`default_nettype none
package nsdn_pkg;
    localparam int NodeBits = 8;
    localparam int NumDirs  = 4;
    localparam int DirBits  = 2;
    localparam int PtrBits  = 3;

    localparam logic [2:0] LOCAL_DIR = 3'(NumDirs);

    // segment tag kinds
    localparam logic [1:0] TAG_FREE     = 2'd0;
    localparam logic [1:0] TAG_ASSIGNED = 2'd1;
    localparam logic [1:0] TAG_INVALID  = 2'd2;

    // opcodes
    localparam logic [1:0] OP_PACKET  = 2'd0;
    localparam logic [1:0] OP_TICK    = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;
    // unused opcode, answered with an error
    localparam logic [1:0] OP_ILLEGAL = 2'd3;

    // packet kinds
    localparam logic [2:0] K_START_REQ  = 3'd0;
    localparam logic [2:0] K_REQ        = 3'd1;
    localparam logic [2:0] K_START_CONF = 3'd2;
    localparam logic [2:0] K_CONF       = 3'd3;
    localparam logic [2:0] K_CANCEL     = 3'd4;

    // node status
    localparam logic [2:0] ST_FREE     = 3'd0;
    localparam logic [2:0] ST_BOOT     = 3'd1;
    localparam logic [2:0] ST_READY    = 3'd2;
    localparam logic [2:0] ST_ACTIVE   = 3'd3;
    localparam logic [2:0] ST_CSTART   = 3'd4;
    localparam logic [2:0] ST_CAND     = 3'd5;
    localparam logic [2:0] ST_ASSIGNED = 3'd6;

    // actions
    localparam logic [3:0] A_FWD     = 4'd0;
    localparam logic [3:0] A_CONFIRM = 4'd1;
    localparam logic [3:0] A_DISCARD = 4'd2;
    localparam logic [3:0] A_FLOOD   = 4'd3;
    localparam logic [3:0] A_CANCEL  = 4'd4;
    localparam logic [3:0] A_RETRY   = 4'd5;
    localparam logic [3:0] A_ENDCONF = 4'd6;
    localparam logic [3:0] A_ENDCANC = 4'd7;
    localparam logic [3:0] A_SKIP    = 4'd8;
    localparam logic [3:0] A_ERROR   = 4'd9;

    // configuration register indexes
    localparam logic [1:0] CFG_NODE_ID    = 2'd0;
    localparam logic [1:0] CFG_BOOT_NODE  = 2'd1;
    localparam logic [1:0] CFG_BOOT_LIMIT = 2'd2;
    localparam logic [1:0] CFG_LINK_MASK  = 2'd3;

    localparam logic [7:0]  RST_NODE_ID    = 8'd0;
    localparam logic [7:0]  RST_BOOT_NODE  = 8'd0;
    localparam logic [15:0] RST_BOOT_LIMIT = 16'd1000;
    localparam logic [3:0]  RST_LINK_MASK  = 4'hF;

    typedef struct packed {
        logic [1:0] tag;
        logic [7:0] node;
        logic [1:0] link;
    } t_seg;

    typedef struct packed {
        logic [1:0] opcode;
        logic [2:0] pkt_kind;
        logic [7:0] seg_node;
        logic [1:0] seg_link;
        logic [7:0] source_node;
        logic [2:0] arrival_dir;
        logic [1:0] planned_dir;
        logic [7:0] hop_count;
    } t_in_item;

    typedef struct packed {
        logic [3:0] action;
        logic [1:0] route_dir;
        logic       inject_valid;
        logic [2:0] inject_kind;
        logic [7:0] inject_seg_node;
        logic [1:0] inject_seg_link;
        logic [7:0] inject_source;
        logic [1:0] inject_dir;
        logic [7:0] inject_hops;
        logic [2:0] node_status;
    } t_out_item;

    typedef struct packed {
        logic         found;
        logic [1:0]   idx;
        logic [2:0]   ptr;
    } t_scan;
endpackage
`default_nettype wire

>>> src/nsdn_in_if.sv
// Input item channel of the segment discovery node.
`default_nettype none
interface nsdn_in_if;
    logic                valid;
    logic                ready;
    nsdn_pkg::t_in_item  payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> src/nsdn_out_if.sv
// Result item channel of the segment discovery node.
`default_nettype none
interface nsdn_out_if;
    logic                valid;
    logic                ready;
    nsdn_pkg::t_out_item payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> src/noc_segment_discovery_node_top.sv
// Segment discovery controller of one mesh router: input stage, step logic, result stage.
//
//  channel  | dir | handshake      | payload
//  i_item   | in  | valid/ready    | opcode, packet fields, tick or restart
//  o_res    | out | valid/ready    | action, route, injected packet, status
//  i_cfg_*  | in  | write enable   | node id, boot node id, limit, link mask
//
// One item per cycle while the result side takes its results; an item is held in
// the input register, its step is computed there and lands in the result register,
// from which the result transfers.
// The state update and the result register load happen together.
// Reset is synchronous: status starts as bootstrap when the node id equals the
// boot node id (true for the reset values), timeout at bootstrap_limit.
// A stalled result holds the input register; the input side stalls only then.
`default_nettype none
module noc_segment_discovery_node_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    nsdn_in_if.sink          i_item,
    nsdn_out_if.source       o_res
);
    localparam int ND = nsdn_pkg::NumDirs;

    // configuration
    logic [7:0]  r_node_id, r_boot_node;
    logic [15:0] r_boot_limit;
    logic [3:0]  r_link_mask;

    // node state
    logic [2:0]  r_status, n_status;
    logic        r_vis, n_vis, r_tent, n_tent;
    nsdn_pkg::t_seg r_own, n_own;
    nsdn_pkg::t_seg [ND-1:0] r_vtag, n_vtag, r_ttag, n_ttag;
    logic [2:0]  r_ptr, n_ptr;
    logic [1:0]  r_ret, n_ret;
    logic [15:0] r_tmo, n_tmo;

    // pipeline
    logic                r_in_vld;
    nsdn_pkg::t_in_item  r_in;
    logic                r_out_vld;
    nsdn_pkg::t_out_item r_out, n_out;
    logic                adv;

    // working copies
    logic [2:0]  w_status;
    logic        w_vis, w_tent, ok, sok, mine, hit;
    nsdn_pkg::t_seg w_own, p, fs, s;
    nsdn_pkg::t_seg [ND-1:0] w_vtag, w_ttag;
    logic [2:0]  w_ptr;
    logic [1:0]  w_ret, d, rp;
    logic [15:0] w_tmo;
    nsdn_pkg::t_out_item res;
    nsdn_pkg::t_scan sc;

    assign adv = r_in_vld && (!r_out_vld || o_res.ready);
    assign i_item.ready = !r_in_vld || adv;
    assign o_res.valid = r_out_vld;
    assign o_res.payload = r_out;

    function automatic nsdn_pkg::t_scan scan_free(
        input nsdn_pkg::t_seg [ND-1:0] vt,
        input nsdn_pkg::t_seg [ND-1:0] tt,
        input logic [2:0] ptr
    );
        nsdn_pkg::t_scan r;
        r.found = 1'b0;
        r.idx = '0;
        r.ptr = 3'(ND);
        for (int i = ND - 1; i >= 0; i--) begin
            if (i >= int'(ptr) && vt[i].tag == nsdn_pkg::TAG_FREE &&
                tt[i].tag == nsdn_pkg::TAG_FREE) begin
                r.found = 1'b1;
                r.idx = 2'(i);
                r.ptr = 3'(i + 1);
            end
        end
        return r;
    endfunction

    function automatic logic seg_eq(input nsdn_pkg::t_seg a, input nsdn_pkg::t_seg b);
        return a.tag == nsdn_pkg::TAG_ASSIGNED && b.tag == nsdn_pkg::TAG_ASSIGNED &&
               a.node == b.node && a.link == b.link;
    endfunction

    always_comb begin
        fs = '{tag: nsdn_pkg::TAG_FREE, node: 8'd0, link: 2'd0};
        w_status = r_status;
        w_vis = r_vis;
        w_tent = r_tent;
        w_own = r_own;
        w_vtag = r_vtag;
        w_ttag = r_ttag;
        w_ptr = r_ptr;
        w_ret = r_ret;
        w_tmo = r_tmo;
        res = '0;
        ok = 1'b1;
        hit = 1'b0;
        sc = '0;
        s = fs;
        p = '{tag: nsdn_pkg::TAG_ASSIGNED, node: r_in.seg_node, link: r_in.seg_link};
        d = r_in.arrival_dir[1:0];
        rp = r_ret;
        mine = r_in.source_node == r_node_id;
        unique case (r_status)
            nsdn_pkg::ST_BOOT: sok = r_node_id == r_boot_node && !r_vis && !r_tent;
            nsdn_pkg::ST_READY, nsdn_pkg::ST_ACTIVE, nsdn_pkg::ST_ASSIGNED:
                sok = r_vis && !r_tent;
            nsdn_pkg::ST_CAND: sok = r_tent && !r_vis;
            nsdn_pkg::ST_FREE: sok = !r_vis && !r_tent;
            nsdn_pkg::ST_CSTART: sok = 1'b1;
            default: sok = 1'b0;
        endcase

        unique case (r_in.opcode)
            nsdn_pkg::OP_RESTART: begin
                for (int i = 0; i < ND; i++) begin
                    w_vtag[i] = fs;
                    if (!r_link_mask[i]) w_vtag[i].tag = nsdn_pkg::TAG_INVALID;
                    w_ttag[i] = w_vtag[i];
                end
                w_own = fs;
                w_vis = 1'b0;
                w_tent = 1'b0;
                w_ptr = '0;
                w_ret = '0;
                w_status = (r_node_id == r_boot_node) ? nsdn_pkg::ST_BOOT : nsdn_pkg::ST_FREE;
                w_tmo = r_boot_limit;
                res.action = nsdn_pkg::A_SKIP;
            end
            nsdn_pkg::OP_TICK: begin
                res.action = nsdn_pkg::A_SKIP;
                if (w_status == nsdn_pkg::ST_BOOT) begin
                    sc = scan_free(w_vtag, w_ttag, w_ptr);
                    w_ptr = sc.ptr;
                    if (sc.found) begin
                        s = '{tag: nsdn_pkg::TAG_ASSIGNED, node: r_node_id, link: sc.idx};
                        w_ttag[sc.idx] = s;
                        w_vis = 1'b1;
                        w_status = nsdn_pkg::ST_ACTIVE;
                        res.inject_valid = 1'b1;
                        res.inject_kind = nsdn_pkg::K_START_REQ;
                        res.inject_seg_node = s.node;
                        res.inject_seg_link = s.link;
                        res.inject_source = r_node_id;
                        res.inject_dir = sc.idx;
                    end
                end else if (w_status == nsdn_pkg::ST_ASSIGNED) begin
                    sc = scan_free(w_vtag, w_ttag, w_ptr);
                    if (sc.found) begin
                        w_ptr = sc.ptr;
                        s = '{tag: nsdn_pkg::TAG_ASSIGNED, node: r_node_id, link: sc.idx};
                        w_ttag[sc.idx] = s;
                        w_status = nsdn_pkg::ST_ACTIVE;
                        res.inject_valid = 1'b1;
                        res.inject_kind = nsdn_pkg::K_REQ;
                        res.inject_seg_node = s.node;
                        res.inject_seg_link = s.link;
                        res.inject_source = r_node_id;
                        res.inject_dir = sc.idx;
                    end
                end else if (w_status == nsdn_pkg::ST_CSTART && w_vis) begin
                    if (w_tmo != 16'd0) w_tmo = w_tmo - 16'd1;
                    if (w_tmo == 16'd0) ok = 1'b0;
                end
            end
            nsdn_pkg::OP_PACKET: begin
                if (r_in.pkt_kind > nsdn_pkg::K_CANCEL) begin
                    ok = 1'b0;
                end else if (r_in.arrival_dir >= nsdn_pkg::LOCAL_DIR) begin
                    res.action = nsdn_pkg::A_FWD;
                    res.route_dir = r_in.planned_dir;
                end else begin
                    unique case (r_in.pkt_kind)
                        nsdn_pkg::K_START_REQ: begin
                            if (mine) begin
                                if (w_own.tag != nsdn_pkg::TAG_ASSIGNED) begin
                                    w_own = p;
                                    w_vtag[d] = p;
                                    w_ttag[d] = fs;
                                    w_ptr = '0;
                                    w_status = nsdn_pkg::ST_ASSIGNED;
                                    res.inject_valid = 1'b1;
                                    res.inject_kind = nsdn_pkg::K_START_CONF;
                                    res.inject_seg_node = p.node;
                                    res.inject_seg_link = p.link;
                                    res.inject_source = r_node_id;
                                    res.inject_dir = d;
                                    res.inject_hops = r_in.hop_count;
                                    res.action = nsdn_pkg::A_CONFIRM;
                                end else begin
                                    res.action = nsdn_pkg::A_DISCARD;
                                end
                            end else if (!sok) begin
                                ok = 1'b0;
                            end else if (w_status == nsdn_pkg::ST_FREE) begin
                                w_own = p;
                                w_tent = 1'b1;
                                w_ttag[d] = p;
                                w_ret = d;
                                w_status = nsdn_pkg::ST_CSTART;
                                res.action = nsdn_pkg::A_FLOOD;
                            end else begin
                                res.action = nsdn_pkg::A_DISCARD;
                            end
                        end
                        nsdn_pkg::K_REQ: begin
                            if (mine || !sok) begin
                                ok = 1'b0;
                            end else if (w_status == nsdn_pkg::ST_FREE ||
                                         w_status == nsdn_pkg::ST_CSTART) begin
                                if (w_status == nsdn_pkg::ST_CSTART) begin
                                    for (int i = 0; i < ND; i++) begin
                                        if (w_vtag[i].tag != nsdn_pkg::TAG_INVALID &&
                                            w_ttag[i].tag != nsdn_pkg::TAG_INVALID) begin
                                            w_vtag[i] = fs;
                                            w_ttag[i] = fs;
                                        end
                                    end
                                    w_ptr = '0;
                                end
                                w_vtag[d] = fs;
                                w_ttag[d] = p;
                                sc = scan_free(w_vtag, w_ttag, w_ptr);
                                w_ptr = sc.ptr;
                                if (sc.found) begin
                                    // become candidate
                                    w_own = p;
                                    w_tent = 1'b1;
                                    w_vis = 1'b0;
                                    w_ttag[sc.idx] = p;
                                    w_status = nsdn_pkg::ST_CAND;
                                    w_ret = d;
                                    res.action = nsdn_pkg::A_FWD;
                                    res.route_dir = sc.idx;
                                end else if (w_status == nsdn_pkg::ST_CSTART) begin
                                    ok = 1'b0;
                                end else begin
                                    w_ttag[d] = fs;
                                    res.action = nsdn_pkg::A_CANCEL;
                                end
                            end else if (w_status == nsdn_pkg::ST_ACTIVE ||
                                         w_status == nsdn_pkg::ST_ASSIGNED) begin
                                w_vtag[d] = p;
                                w_ttag[d] = fs;
                                res.inject_valid = 1'b1;
                                res.inject_kind = nsdn_pkg::K_CONF;
                                res.inject_seg_node = p.node;
                                res.inject_seg_link = p.link;
                                res.inject_source = r_node_id;
                                res.inject_dir = d;
                                res.inject_hops = r_in.hop_count;
                                w_ret = d;
                                res.action = nsdn_pkg::A_CONFIRM;
                            end else if (w_status == nsdn_pkg::ST_CAND) begin
                                if (seg_eq(w_own, p)) begin
                                    // first tentative link carrying the segment, not the way back
                                    for (int i = ND - 1; i >= 0; i--) begin
                                        if (seg_eq(w_ttag[i], p) && 2'(i) != rp) begin
                                            hit = 1'b1;
                                            res.route_dir = 2'(i);
                                        end
                                    end
                                    res.action = nsdn_pkg::A_FWD;
                                    if (!hit) ok = 1'b0;
                                end else begin
                                    if (w_vtag[d].tag != nsdn_pkg::TAG_ASSIGNED) w_vtag[d] = fs;
                                    w_ttag[d] = fs;
                                    res.inject_valid = 1'b1;
                                    res.inject_kind = nsdn_pkg::K_CANCEL;
                                    res.inject_seg_node = p.node;
                                    res.inject_seg_link = p.link;
                                    res.inject_source = r_node_id;
                                    res.inject_dir = d;
                                    res.inject_hops = r_in.hop_count;
                                    res.action = nsdn_pkg::A_CANCEL;
                                end
                            end else begin
                                ok = 1'b0;
                            end
                        end
                        nsdn_pkg::K_START_CONF: begin
                            if (mine) begin
                                w_status = nsdn_pkg::ST_ASSIGNED;
                                w_vtag[d] = p;
                                w_ttag[d] = fs;
                                res.action = nsdn_pkg::A_ENDCONF;
                            end else if (!sok || w_status != nsdn_pkg::ST_CSTART ||
                                         !seg_eq(w_own, p)) begin
                                ok = 1'b0;
                            end else begin
                                w_tent = 1'b0;
                                w_vis = 1'b1;
                                w_vtag[d] = p;
                                w_ttag[d] = fs;
                                w_vtag[rp] = p;
                                w_ttag[rp] = fs;
                                for (int i = 0; i < ND; i++) begin
                                    if (2'(i) != rp && 2'(i) != d &&
                                        w_vtag[i].tag != nsdn_pkg::TAG_INVALID) begin
                                        w_vtag[i] = fs;
                                        w_ttag[i] = fs;
                                    end
                                end
                                w_ptr = '0;
                                w_status = nsdn_pkg::ST_ASSIGNED;
                                res.action = nsdn_pkg::A_FWD;
                                res.route_dir = rp;
                            end
                        end
                        nsdn_pkg::K_CONF: begin
                            if (mine) begin
                                ok = 1'b0;
                            end else if (p.node == r_node_id) begin
                                w_vtag[d] = p;
                                w_ttag[d] = fs;
                                w_status = nsdn_pkg::ST_ASSIGNED;
                                res.action = nsdn_pkg::A_ENDCONF;
                            end else if (!sok || w_status != nsdn_pkg::ST_CAND ||
                                         !seg_eq(w_own, p)) begin
                                ok = 1'b0;
                            end else begin
                                w_status = nsdn_pkg::ST_ASSIGNED;
                                w_tent = 1'b0;
                                w_vis = 1'b1;
                                w_vtag[d] = p;
                                w_ttag[d] = fs;
                                w_vtag[rp] = p;
                                w_ttag[rp] = fs;
                                res.action = nsdn_pkg::A_FWD;
                                res.route_dir = rp;
                            end
                        end
                        default: begin
                            sc = scan_free(w_vtag, w_ttag, w_ptr);
                            w_ptr = sc.ptr;
                            if (sc.found) begin
                                w_ttag[sc.idx] = p;
                                if (w_vtag[d].tag != nsdn_pkg::TAG_ASSIGNED) w_vtag[d] = fs;
                                w_ttag[d] = fs;
                                res.inject_valid = 1'b1;
                                res.inject_kind = nsdn_pkg::K_REQ;
                                res.inject_seg_node = p.node;
                                res.inject_seg_link = p.link;
                                res.inject_source = p.node;
                                res.inject_dir = sc.idx;
                                res.inject_hops = r_in.hop_count;
                                res.action = nsdn_pkg::A_RETRY;
                            end else begin
                                if (w_vtag[d].tag != nsdn_pkg::TAG_ASSIGNED) w_vtag[d] = fs;
                                w_ttag[d] = fs;
                                if (r_node_id == p.node) begin
                                    res.action = nsdn_pkg::A_ENDCANC;
                                end else begin
                                    if (w_vtag[rp].tag != nsdn_pkg::TAG_ASSIGNED) w_vtag[rp] = fs;
                                    w_ttag[rp] = fs;
                                    w_tent = 1'b0;
                                    w_vis = 1'b0;
                                    w_status = nsdn_pkg::ST_FREE;
                                    res.action = nsdn_pkg::A_FWD;
                                    res.route_dir = rp;
                                end
                            end
                        end
                    endcase
                end
            end
            default: ok = 1'b0;
        endcase

        if (ok) begin
            n_status = w_status;
            n_vis = w_vis;
            n_tent = w_tent;
            n_own = w_own;
            n_vtag = w_vtag;
            n_ttag = w_ttag;
            n_ptr = w_ptr;
            n_ret = w_ret;
            n_tmo = w_tmo;
            n_out = res;
        end else begin
            n_status = r_status;
            n_vis = r_vis;
            n_tent = r_tent;
            n_own = r_own;
            n_vtag = r_vtag;
            n_ttag = r_ttag;
            n_ptr = r_ptr;
            n_ret = r_ret;
            n_tmo = r_tmo;
            n_out = '0;
            n_out.action = nsdn_pkg::A_ERROR;
        end
        n_out.node_status = n_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_id <= nsdn_pkg::RST_NODE_ID;
            r_boot_node <= nsdn_pkg::RST_BOOT_NODE;
            r_boot_limit <= nsdn_pkg::RST_BOOT_LIMIT;
            r_link_mask <= nsdn_pkg::RST_LINK_MASK;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                nsdn_pkg::CFG_NODE_ID:    r_node_id <= i_cfg_data[7:0];
                nsdn_pkg::CFG_BOOT_NODE:  r_boot_node <= i_cfg_data[7:0];
                nsdn_pkg::CFG_BOOT_LIMIT: r_boot_limit <= i_cfg_data;
                default:                  r_link_mask <= i_cfg_data[3:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status <= (nsdn_pkg::RST_NODE_ID == nsdn_pkg::RST_BOOT_NODE) ?
                        nsdn_pkg::ST_BOOT : nsdn_pkg::ST_FREE;
            r_vis <= 1'b0;
            r_tent <= 1'b0;
            r_own <= '0;
            for (int i = 0; i < ND; i++) begin
                r_vtag[i] <= '{tag: nsdn_pkg::RST_LINK_MASK[i] ? nsdn_pkg::TAG_FREE
                                                               : nsdn_pkg::TAG_INVALID,
                               node: 8'd0, link: 2'd0};
                r_ttag[i] <= '{tag: nsdn_pkg::RST_LINK_MASK[i] ? nsdn_pkg::TAG_FREE
                                                               : nsdn_pkg::TAG_INVALID,
                               node: 8'd0, link: 2'd0};
            end
            r_ptr <= '0;
            r_ret <= '0;
            r_tmo <= nsdn_pkg::RST_BOOT_LIMIT;
            r_in_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_item.valid && i_item.ready) begin
                r_in_vld <= 1'b1;
            end else if (adv) begin
                r_in_vld <= 1'b0;
            end
            if (adv) begin
                r_status <= n_status;
                r_vis <= n_vis;
                r_tent <= n_tent;
                r_own <= n_own;
                r_vtag <= n_vtag;
                r_ttag <= n_ttag;
                r_ptr <= n_ptr;
                r_ret <= n_ret;
                r_tmo <= n_tmo;
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) r_in <= i_item.payload;
        if (adv) r_out <= n_out;
    end

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= 3'(ND)) else $error("scan pointer past last link");
    a_err_no_inject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out.action == nsdn_pkg::A_ERROR |-> !r_out.inject_valid)
        else $error("error result carries a packet");
    a_err_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && !ok |=> r_status == $past(r_status) && r_ptr == $past(r_ptr))
        else $error("error step changed state");
    a_status_reported: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> r_out.node_status == r_status)
        else $error("reported status differs from state");
endmodule
`default_nettype wire
